// ----- src/ctp_pkg.sv -----
// Shared types, widths and codes for the collision time predictor.
// Depends on nothing; every other file in the block imports it.
package ctp_pkg;

   // Fixed point scale of positions, radii and times.
   localparam int FRAC_BITS = 16;

   // Port field widths.
   localparam int TYPE_W = 2;
   localparam int NOW_W  = 32;
   localparam int POS_W  = 16;
   localparam int VEL_W  = 18;
   localparam int RAD_W  = 13;
   localparam int HOR_W  = 20;
   localparam int MAR_W  = 10;
   localparam int CSR_W  = 20;

   // Internal datapath widths.
   localparam int DP_W    = POS_W + 1;            // position difference, signed
   localparam int DV_W    = VEL_W + 1;            // velocity difference, signed
   localparam int S_W     = RAD_W + 2;            // summed radii plus margin
   localparam int PV_W    = DP_W + DV_W;          // dp * dv product, signed
   localparam int B_W     = PV_W + 1;             // dot product b, signed
   localparam int NB_W    = B_W - 2;              // magnitude of a negative b
   localparam int VV_W    = 2 * DV_W;             // dv . dv
   localparam int PP_W    = 2 * DP_W;             // single dp * dp term, signed
   localparam int SS_W    = 2 * S_W;              // s * s
   localparam int E_W     = PP_W + 1;             // pp - s*s, signed
   localparam int EU_W    = PP_W;                 // pp - s*s when not negative
   localparam int WD_W    = ((FRAC_BITS > POS_W) ? FRAC_BITS : POS_W) + 2;
   localparam int NUM_W   = NB_W;                 // numerator before scaling
   localparam int DEN_W   = VV_W;                 // divisor
   localparam int ROOT_W  = NB_W;                 // square root result
   localparam int D_W     = 2 * ROOT_W;           // discriminant
   localparam int P_W     = VV_W + EU_W;          // wide products b*b and vv*e
   localparam int Q_W     = HOR_W;                // quotient bits kept
   localparam int N_W     = NUM_W + FRAC_BITS;
   localparam int REM_W   = (N_W > DEN_W + Q_W) ? N_W : DEN_W + Q_W;

   // Split points for the wide multiplications.
   localparam int NB_LO = NB_W / 2 + 1;
   localparam int VV_LO = VV_W / 2;
   localparam int E_LO  = EU_W / 2;

   // Reset values of the configuration registers.
   localparam logic [HOR_W-1:0] HORIZON_RESET = HOR_W'(655360);
   localparam logic [MAR_W-1:0] MARGIN_RESET  = MAR_W'(66);

   // Request kinds.
   typedef enum logic [TYPE_W-1:0] {
      REQ_PAIR   = 2'd0,
      REQ_WALL_X = 2'd1,
      REQ_WALL_Y = 2'd2
   } ctp_kind_type;

   // Configuration register indexes.
   typedef enum logic [0:0] {
      CSR_HORIZON = 1'b0,
      CSR_MARGIN  = 1'b1
   } ctp_csr_type;

   // Sideband carried through the square root pipeline.
   typedef struct packed {
      logic             pair;
      logic             miss;
      logic             zero;
      logic [NOW_W-1:0] now;
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
   } ctp_sside_type;

   // Sideband carried through the divider pipeline.
   typedef struct packed {
      logic             miss;
      logic             zero;
      logic             ovf;
      logic [NOW_W-1:0] now;
   } ctp_dside_type;

endpackage

// ----- src/collision_time_predictor.sv -----
// Collision time predictor: disk-disk and disk-wall contact times, pipelined.
// Depends on ctp_pkg, ctp_isqrt and ctp_divider.
//
// Usage:
//   Request channel (req_*): one transaction per prediction. req_type selects a
//   disk pair, a wall in x or a wall in y. Disk B fields matter only for pairs.
//   Response channel (rsp_*): one transaction per request, in request order,
//   carrying rsp_hit and the absolute contact time rsp_event_time.
//   Configuration (csr_*): csr_write with csr_index writes horizon_time (0) or
//   contact_margin (1); write only while no request is in flight.
// Pipeline:
//   The 64 registers between request and response are six front stages for the
//   dot products and the discriminant, 35 square root stages (one root bit
//   each), one stage for the numerator, 21 divider stages (overflow check plus
//   one quotient bit each) and the output register.
//   One request is accepted per cycle while req_stall is low.
// Reset and stall:
//   Reset empties the pipeline and loads the register defaults. When the
//   receiver stalls, a skid register takes one more transaction; once it is
//   full, req_stall rises and the whole pipeline holds until the output drains.
module collision_time_predictor (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [ctp_pkg::TYPE_W-1:0]    req_type,
   input  logic [ctp_pkg::NOW_W-1:0]     req_now_time,
   input  logic [ctp_pkg::POS_W-1:0]     req_pos_ax,
   input  logic [ctp_pkg::POS_W-1:0]     req_pos_ay,
   input  logic signed [ctp_pkg::VEL_W-1:0] req_vel_ax,
   input  logic signed [ctp_pkg::VEL_W-1:0] req_vel_ay,
   input  logic [ctp_pkg::RAD_W-1:0]     req_radius_a,
   input  logic [ctp_pkg::POS_W-1:0]     req_pos_bx,
   input  logic [ctp_pkg::POS_W-1:0]     req_pos_by,
   input  logic signed [ctp_pkg::VEL_W-1:0] req_vel_bx,
   input  logic signed [ctp_pkg::VEL_W-1:0] req_vel_by,
   input  logic [ctp_pkg::RAD_W-1:0]     req_radius_b,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_hit,
   output logic [ctp_pkg::NOW_W-1:0]     rsp_event_time,
   // configuration port
   input  logic                          csr_write,
   input  logic                          csr_index,
   input  logic [ctp_pkg::CSR_W-1:0]     csr_wdata
);
   import ctp_pkg::*;

   logic adv;

   // ------------------------------------------------------------------
   // Configuration registers.
   logic [HOR_W-1:0] horizon_ff;
   logic [MAR_W-1:0] margin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         horizon_ff <= HORIZON_RESET;
         margin_ff  <= MARGIN_RESET;
      end else if (csr_write) begin
         unique case (ctp_csr_type'(csr_index))
            CSR_HORIZON: horizon_ff <= csr_wdata[HOR_W-1:0];
            CSR_MARGIN:  margin_ff  <= csr_wdata[MAR_W-1:0];
            default:     ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: differences, summed radii and wall axis selection.
   logic                    s1_vld_ff;
   logic [NOW_W-1:0]        s1_now_ff;
   logic                    s1_pair_ff, s1_miss_ff;
   logic signed [DP_W-1:0]  s1_dpx_ff, s1_dpy_ff;
   logic signed [DV_W-1:0]  s1_dvx_ff, s1_dvy_ff;
   logic [S_W-1:0]          s1_sum_ff;
   logic [POS_W-1:0]        s1_wp_ff;
   logic signed [VEL_W-1:0] s1_wv_ff;
   logic [RAD_W-1:0]        s1_wr_ff;

   logic                    s1_pair_in, s1_miss_in, s1_ysel;
   logic signed [DP_W-1:0]  s1_dpx_in, s1_dpy_in;
   logic signed [DV_W-1:0]  s1_dvx_in, s1_dvy_in;
   logic [S_W-1:0]          s1_sum_in;

   always_comb begin
      s1_pair_in = (req_type == REQ_PAIR);
      s1_ysel    = (req_type == REQ_WALL_Y);
      s1_miss_in = !(s1_pair_in || s1_ysel || (req_type == REQ_WALL_X));
      s1_dpx_in  = $signed({1'b0, req_pos_bx}) - $signed({1'b0, req_pos_ax});
      s1_dpy_in  = $signed({1'b0, req_pos_by}) - $signed({1'b0, req_pos_ay});
      s1_dvx_in  = $signed({req_vel_bx[VEL_W-1], req_vel_bx})
                 - $signed({req_vel_ax[VEL_W-1], req_vel_ax});
      s1_dvy_in  = $signed({req_vel_by[VEL_W-1], req_vel_by})
                 - $signed({req_vel_ay[VEL_W-1], req_vel_ay});
      s1_sum_in  = S_W'(req_radius_a) + S_W'(req_radius_b) + S_W'(margin_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_now_ff  <= req_now_time;
         s1_pair_ff <= s1_pair_in;
         s1_miss_ff <= s1_miss_in;
         s1_dpx_ff  <= s1_dpx_in;
         s1_dpy_ff  <= s1_dpy_in;
         s1_dvx_ff  <= s1_dvx_in;
         s1_dvy_ff  <= s1_dvy_in;
         s1_sum_ff  <= s1_sum_in;
         s1_wp_ff   <= s1_ysel ? req_pos_ay : req_pos_ax;
         s1_wv_ff   <= s1_ysel ? req_vel_ay : req_vel_ax;
         s1_wr_ff   <= req_radius_a;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: products of the pair terms; wall distance and speed.
   logic                    s2_vld_ff;
   logic [NOW_W-1:0]        s2_now_ff;
   logic                    s2_pair_ff, s2_miss_ff, s2_wzero_ff;
   logic signed [PV_W-1:0]  s2_pxvx_ff, s2_pyvy_ff;
   logic signed [VV_W-1:0]  s2_vx2_ff, s2_vy2_ff;
   logic signed [PP_W-1:0]  s2_px2_ff, s2_py2_ff;
   logic [SS_W-1:0]         s2_ss_ff;
   logic [WD_W-1:0]         s2_wdist_ff;
   logic [VEL_W-1:0]        s2_wspeed_ff;

   logic                    s2_vpos, s2_vzero, s2_wzero_in;
   logic [WD_W-1:0]         s2_wdist_in;
   logic [VEL_W-1:0]        s2_wspeed_in;

   always_comb begin
      s2_vzero     = (s1_wv_ff == '0);
      s2_vpos      = !s1_wv_ff[VEL_W-1] && !s2_vzero;
      s2_wdist_in  = s2_vpos
                   ? (WD_W'(1) << FRAC_BITS) - WD_W'(s1_wr_ff) - WD_W'(s1_wp_ff)
                   : WD_W'(s1_wp_ff) - WD_W'(s1_wr_ff);
      s2_wspeed_in = s1_wv_ff[VEL_W-1] ? VEL_W'(-s1_wv_ff) : VEL_W'(s1_wv_ff);
      s2_wzero_in  = s2_wdist_in[WD_W-1] || (s2_wdist_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (adv) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_now_ff    <= s1_now_ff;
         s2_pair_ff   <= s1_pair_ff;
         s2_miss_ff   <= s1_miss_ff || (!s1_pair_ff && s2_vzero);
         s2_wzero_ff  <= s2_wzero_in;
         s2_pxvx_ff   <= s1_dpx_ff * s1_dvx_ff;
         s2_pyvy_ff   <= s1_dpy_ff * s1_dvy_ff;
         s2_vx2_ff    <= s1_dvx_ff * s1_dvx_ff;
         s2_vy2_ff    <= s1_dvy_ff * s1_dvy_ff;
         s2_px2_ff    <= s1_dpx_ff * s1_dpx_ff;
         s2_py2_ff    <= s1_dpy_ff * s1_dpy_ff;
         s2_ss_ff     <= s1_sum_ff * s1_sum_ff;
         s2_wdist_ff  <= s2_wdist_in;
         s2_wspeed_ff <= s2_wspeed_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: dot products, overlap test; numerator and divisor chosen.
   logic                    s3_vld_ff;
   logic [NOW_W-1:0]        s3_now_ff;
   logic                    s3_pair_ff, s3_miss_ff, s3_zero_ff;
   logic [NUM_W-1:0]        s3_num_ff;
   logic [DEN_W-1:0]        s3_den_ff;
   logic [EU_W-1:0]         s3_e_ff;

   logic signed [B_W-1:0]   s3_b;
   logic signed [E_W-1:0]   s3_e;
   logic [VV_W-1:0]         s3_vv;

   always_comb begin
      s3_b  = B_W'(s2_pxvx_ff) + B_W'(s2_pyvy_ff);
      s3_vv = VV_W'(s2_vx2_ff + s2_vy2_ff);
      s3_e  = E_W'(s2_px2_ff) + E_W'(s2_py2_ff) - E_W'(s2_ss_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (adv) begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_now_ff  <= s2_now_ff;
         s3_pair_ff <= s2_pair_ff;
         // A pair that is not closing in never touches.
         s3_miss_ff <= s2_miss_ff || (s2_pair_ff && !s3_b[B_W-1]);
         s3_zero_ff <= s2_pair_ff ? s3_e[E_W-1] : s2_wzero_ff;
         s3_num_ff  <= s2_pair_ff ? NUM_W'(-s3_b) : NUM_W'(s2_wdist_ff);
         s3_den_ff  <= s2_pair_ff ? s3_vv : DEN_W'(s2_wspeed_ff);
         s3_e_ff    <= s3_e[EU_W-1:0];
      end
   end

   // ------------------------------------------------------------------
   // Stage 4: partial products of b*b and vv*e.
   logic                         s4_vld_ff;
   logic [NOW_W-1:0]             s4_now_ff;
   logic                         s4_pair_ff, s4_miss_ff, s4_zero_ff;
   logic [NUM_W-1:0]             s4_num_ff;
   logic [DEN_W-1:0]             s4_den_ff;
   logic [2*(NB_W-NB_LO)-1:0]    s4_bhh_ff;
   logic [NB_W-1:0]              s4_bhl_ff;
   logic [2*NB_LO-1:0]           s4_bll_ff;
   logic [VV_W-VV_LO+EU_W-E_LO-1:0] s4_vhh_ff;
   logic [VV_W-VV_LO+E_LO-1:0]   s4_vhl_ff;
   logic [VV_LO+EU_W-E_LO-1:0]   s4_vlh_ff;
   logic [VV_LO+E_LO-1:0]        s4_vll_ff;

   logic [NB_W-NB_LO-1:0]        s4_nh;
   logic [NB_LO-1:0]             s4_nl;
   logic [VV_W-VV_LO-1:0]        s4_vh;
   logic [VV_LO-1:0]             s4_vl;
   logic [EU_W-E_LO-1:0]         s4_eh;
   logic [E_LO-1:0]              s4_el;

   always_comb begin
      s4_nh = s3_num_ff[NB_W-1:NB_LO];
      s4_nl = s3_num_ff[NB_LO-1:0];
      s4_vh = s3_den_ff[VV_W-1:VV_LO];
      s4_vl = s3_den_ff[VV_LO-1:0];
      s4_eh = s3_e_ff[EU_W-1:E_LO];
      s4_el = s3_e_ff[E_LO-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else if (adv) begin
         s4_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_now_ff  <= s3_now_ff;
         s4_pair_ff <= s3_pair_ff;
         s4_miss_ff <= s3_miss_ff;
         s4_zero_ff <= s3_zero_ff;
         s4_num_ff  <= s3_num_ff;
         s4_den_ff  <= s3_den_ff;
         s4_bhh_ff  <= s4_nh * s4_nh;
         s4_bhl_ff  <= s4_nh * s4_nl;
         s4_bll_ff  <= s4_nl * s4_nl;
         s4_vhh_ff  <= s4_vh * s4_eh;
         s4_vhl_ff  <= s4_vh * s4_el;
         s4_vlh_ff  <= s4_vl * s4_eh;
         s4_vll_ff  <= s4_vl * s4_el;
      end
   end

   // ------------------------------------------------------------------
   // Stage 5: assemble b*b and vv*e.
   logic                    s5_vld_ff;
   logic [NOW_W-1:0]        s5_now_ff;
   logic                    s5_pair_ff, s5_miss_ff, s5_zero_ff;
   logic [NUM_W-1:0]        s5_num_ff;
   logic [DEN_W-1:0]        s5_den_ff;
   logic [P_W-1:0]          s5_b2_ff, s5_ve_ff;

   logic [P_W-1:0]          s5_b2_in, s5_ve_in;

   always_comb begin
      s5_b2_in = (P_W'(s4_bhh_ff) << (2 * NB_LO))
               + (P_W'(s4_bhl_ff) << (NB_LO + 1))
               + P_W'(s4_bll_ff);
      s5_ve_in = (P_W'(s4_vhh_ff) << (VV_LO + E_LO))
               + (P_W'(s4_vhl_ff) << VV_LO)
               + (P_W'(s4_vlh_ff) << E_LO)
               + P_W'(s4_vll_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_vld_ff <= 1'b0;
      end else if (adv) begin
         s5_vld_ff <= s4_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s5_now_ff  <= s4_now_ff;
         s5_pair_ff <= s4_pair_ff;
         s5_miss_ff <= s4_miss_ff;
         s5_zero_ff <= s4_zero_ff;
         s5_num_ff  <= s4_num_ff;
         s5_den_ff  <= s4_den_ff;
         s5_b2_ff   <= s5_b2_in;
         s5_ve_ff   <= s5_ve_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 6: discriminant and its sign.
   logic                    s6_vld_ff;
   ctp_sside_type           s6_side_ff;
   logic [D_W-1:0]          s6_d_ff;

   logic                    s6_neg;
   logic [P_W-1:0]          s6_d;
   ctp_sside_type           s6_side_in;

   always_comb begin
      s6_neg          = s5_ve_ff > s5_b2_ff;
      s6_d            = s5_b2_ff - s5_ve_ff;
      s6_side_in.pair = s5_pair_ff;
      // A negative discriminant only counts when the disks do not overlap yet.
      s6_side_in.miss = s5_miss_ff || (s5_pair_ff && !s5_zero_ff && s6_neg);
      s6_side_in.zero = s5_zero_ff;
      s6_side_in.now  = s5_now_ff;
      s6_side_in.num  = s5_num_ff;
      s6_side_in.den  = s5_den_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_vld_ff <= 1'b0;
      end else if (adv) begin
         s6_vld_ff <= s5_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s6_side_ff <= s6_side_in;
         s6_d_ff    <= s6_d[D_W-1:0];
      end
   end

   // ------------------------------------------------------------------
   // Square root of the discriminant.
   logic                    sq_vld;
   logic [ROOT_W-1:0]       sq_root;
   ctp_sside_type           sq_side;

   ctp_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (s6_vld_ff),
      .in_rad    (s6_d_ff),
      .in_side   (s6_side_ff),
      .out_valid (sq_vld),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // ------------------------------------------------------------------
   // Stage 7: numerator -b - root for pairs, wall distance as it is.
   logic                    s7_vld_ff;
   logic [NUM_W-1:0]        s7_num_ff;
   logic [DEN_W-1:0]        s7_den_ff;
   ctp_dside_type           s7_side_ff;

   ctp_dside_type           s7_side_in;

   always_comb begin
      s7_side_in.miss = sq_side.miss;
      s7_side_in.zero = sq_side.zero;
      s7_side_in.ovf  = 1'b0;
      s7_side_in.now  = sq_side.now;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_vld_ff <= 1'b0;
      end else if (adv) begin
         s7_vld_ff <= sq_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s7_num_ff  <= sq_side.pair ? sq_side.num - sq_root : sq_side.num;
         s7_den_ff  <= sq_side.den;
         s7_side_ff <= s7_side_in;
      end
   end

   // ------------------------------------------------------------------
   // Time to contact as num * 2^FRAC_BITS / den.
   logic                    dv_vld;
   logic [Q_W-1:0]          dv_quot;
   ctp_dside_type           dv_side;

   ctp_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (s7_vld_ff),
      .in_num    (s7_num_ff),
      .in_den    (s7_den_ff),
      .in_side   (s7_side_ff),
      .out_valid (dv_vld),
      .out_quot  (dv_quot),
      .out_side  (dv_side)
   );

   // ------------------------------------------------------------------
   // Horizon test and saturating absolute time.
   logic [Q_W-1:0]          fin_t;
   logic [NOW_W:0]          fin_sum;
   logic                    fin_hit;
   logic [NOW_W-1:0]        fin_time;

   always_comb begin
      fin_t    = dv_side.zero ? '0 : dv_quot;
      fin_hit  = !dv_side.miss && (dv_side.zero || !dv_side.ovf)
               && (fin_t <= horizon_ff);
      fin_sum  = {1'b0, dv_side.now} + (NOW_W + 1)'(fin_t);
      if (!fin_hit) begin
         fin_time = '0;
      end else if (fin_sum[NOW_W]) begin
         fin_time = '1;
      end else begin
         fin_time = fin_sum[NOW_W-1:0];
      end
   end

   // ------------------------------------------------------------------
   // Output register with one skid entry; the pipeline holds while it is full.
   logic                    out_v_ff, skid_v_ff;
   logic                    out_hit_ff, skid_hit_ff;
   logic [NOW_W-1:0]        out_time_ff, skid_time_ff;
   logic                    out_free, arrive;

   assign adv = !skid_v_ff;

   always_comb begin
      out_free = !out_v_ff || !rsp_stall;
      arrive   = dv_vld && adv;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (out_free) begin
         out_v_ff  <= skid_v_ff || arrive;
         skid_v_ff <= 1'b0;
      end else if (arrive) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_hit_ff  <= skid_v_ff ? skid_hit_ff : fin_hit;
         out_time_ff <= skid_v_ff ? skid_time_ff : fin_time;
      end else if (arrive) begin
         skid_hit_ff  <= fin_hit;
         skid_time_ff <= fin_time;
      end
   end

   assign req_stall      = skid_v_ff;
   assign rsp_valid      = out_v_ff;
   assign rsp_hit        = out_hit_ff;
   assign rsp_event_time = out_time_ff;

   // ------------------------------------------------------------------
   // Checks.
   a_skid_behind_out : assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid entry held while the output register is empty");

   a_skid_holds : assert property (@(posedge clock) disable iff (reset)
      (skid_v_ff && rsp_stall) |=> skid_v_ff)
      else $error("skid entry lost while the receiver stalls");

   a_miss_zero_time : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |-> (rsp_event_time == '0))
      else $error("event time not zero on a miss");

   a_stall_freezes : assert property (@(posedge clock) disable iff (reset)
      (skid_v_ff && !out_free) |=> $stable(dv_side))
      else $error("pipeline moved while the skid entry is full");

endmodule

// ----- src/ctp_isqrt.sv -----
// Pipelined floor square root, one result bit per register stage.
// Depends on ctp_pkg for widths and the sideband struct.
module ctp_isqrt (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         adv,
   input  logic                         in_valid,
   input  logic [ctp_pkg::D_W-1:0]      in_rad,
   input  ctp_pkg::ctp_sside_type       in_side,
   output logic                         out_valid,
   output logic [ctp_pkg::ROOT_W-1:0]   out_root,
   output ctp_pkg::ctp_sside_type       out_side
);
   import ctp_pkg::*;

   logic                vld_ff  [ROOT_W];
   logic [D_W-1:0]      rem_ff  [ROOT_W];
   logic [ROOT_W-1:0]   root_ff [ROOT_W];
   ctp_sside_type       side_ff [ROOT_W];

   genvar k;
   for (k = 0; k < ROOT_W; k++) begin : g_stage
      localparam int BIT = ROOT_W - 1 - k;
      logic              pv;
      logic [D_W-1:0]    prem;
      logic [ROOT_W-1:0] proot;
      ctp_sside_type     pside;
      logic [D_W-1:0]    trial;
      logic [D_W-1:0]    rem_in;
      logic [ROOT_W-1:0] root_in;

      if (k == 0) begin : g_first
         assign pv    = in_valid;
         assign prem  = in_rad;
         assign proot = '0;
         assign pside = in_side;
      end else begin : g_next
         assign pv    = vld_ff[k-1];
         assign prem  = rem_ff[k-1];
         assign proot = root_ff[k-1];
         assign pside = side_ff[k-1];
      end

      // (root + 2^BIT)^2 - root^2 has no overlapping bits, so it is an OR.
      always_comb begin
         trial = (D_W'(proot) << (BIT + 1)) | (D_W'(1) << (2 * BIT));
         if (prem >= trial) begin
            rem_in  = prem - trial;
            root_in = proot | (ROOT_W'(1) << BIT);
         end else begin
            rem_in  = prem;
            root_in = proot;
         end
      end

      // Stage valid bit.
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv) begin
            vld_ff[k] <= pv;
         end
      end

      // Stage payload.
      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            side_ff[k] <= pside;
         end
      end
   end

   assign out_valid = vld_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_side  = side_ff[ROOT_W-1];

endmodule

// ----- src/ctp_divider.sv -----
// Pipelined restoring divider: overflow check, then one quotient bit per stage.
// Depends on ctp_pkg for widths and the sideband struct.
module ctp_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         adv,
   input  logic                         in_valid,
   input  logic [ctp_pkg::NUM_W-1:0]    in_num,
   input  logic [ctp_pkg::DEN_W-1:0]    in_den,
   input  ctp_pkg::ctp_dside_type       in_side,
   output logic                         out_valid,
   output logic [ctp_pkg::Q_W-1:0]      out_quot,
   output ctp_pkg::ctp_dside_type       out_side
);
   import ctp_pkg::*;

   localparam int NST = Q_W + 1;

   logic               vld_ff  [NST];
   logic [REM_W-1:0]   rem_ff  [NST];
   logic [DEN_W-1:0]   den_ff  [NST];
   logic [Q_W-1:0]     quot_ff [NST];
   ctp_dside_type      side_ff [NST];

   logic [REM_W-1:0]   rem0_in;
   ctp_dside_type      side0_in;

   // Scale the numerator and flag quotients that do not fit in Q_W bits.
   always_comb begin
      rem0_in      = REM_W'(in_num) << FRAC_BITS;
      side0_in     = in_side;
      side0_in.ovf = rem0_in >= (REM_W'(in_den) << Q_W);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0]  <= rem0_in;
         den_ff[0]  <= in_den;
         quot_ff[0] <= '0;
         side_ff[0] <= side0_in;
      end
   end

   genvar k;
   for (k = 1; k < NST; k++) begin : g_stage
      localparam int BIT = Q_W - k;
      logic [REM_W-1:0] shifted;
      logic [REM_W-1:0] rem_in;
      logic [Q_W-1:0]   quot_in;

      // Subtract the shifted divisor where it fits.
      always_comb begin
         shifted = REM_W'(den_ff[k-1]) << BIT;
         if (rem_ff[k-1] >= shifted) begin
            rem_in  = rem_ff[k-1] - shifted;
            quot_in = quot_ff[k-1] | (Q_W'(1) << BIT);
         end else begin
            rem_in  = rem_ff[k-1];
            quot_in = quot_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k]  <= rem_in;
            den_ff[k]  <= den_ff[k-1];
            quot_ff[k] <= quot_in;
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign out_valid = vld_ff[NST-1];
   assign out_quot  = quot_ff[NST-1];
   assign out_side  = side_ff[NST-1];

endmodule

// ----- dv/collision_time_predictor_test.sv -----
// Self-checking testbench for the collision time predictor.
// Depends on ctp_pkg and collision_time_predictor; drives directed and random
// predictions through the pipeline and checks each response against a predictor.
module collision_time_predictor_test;
   import ctp_pkg::*;

   localparam int LATENCY = 64;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [TYPE_W-1:0]        req_type;
   logic [NOW_W-1:0]         req_now_time;
   logic [POS_W-1:0]         req_pos_ax, req_pos_ay, req_pos_bx, req_pos_by;
   logic signed [VEL_W-1:0]  req_vel_ax, req_vel_ay, req_vel_bx, req_vel_by;
   logic [RAD_W-1:0]         req_radius_a, req_radius_b;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic                     rsp_hit;
   logic [NOW_W-1:0]         rsp_event_time;
   logic                     csr_write;
   logic                     csr_index;
   logic [CSR_W-1:0]         csr_wdata;

   // One prediction request as the sender sees it.
   typedef struct {
      logic [TYPE_W-1:0]       kind;
      logic [NOW_W-1:0]        now;
      logic [POS_W-1:0]        ax, ay, bx, by;
      logic signed [VEL_W-1:0] vax, vay, vbx, vby;
      logic [RAD_W-1:0]        ra, rb;
   } request_type;

   // One expected response.
   typedef struct {
      logic             hit;
      logic [NOW_W-1:0] when;
   } contact_type;

   // Directed table row; check_fixed marks rows with a typed-in answer.
   typedef struct {
      request_type rq;
      logic        check_fixed;
      contact_type answer;
   } directed_row_type;

   contact_type        pending_contacts[$];
   logic [HOR_W-1:0]   horizon;
   logic [MAR_W-1:0]   margin;
   int                 error_count;
   logic               hold_long;
   logic               stimulus_done;
   directed_row_type   directed[$];

   collision_time_predictor uut (.*);

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard limit on run time.
   initial begin
      #20000000;
      $display("tb: failure");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %0h, want %0h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Floor square root of a 128-bit value, one result bit at a time.
   function automatic logic [63:0] floor_root(input logic [127:0] d);
      logic [63:0] root;
      logic [63:0] cand;
      root = '0;
      for (int bit_idx = 63; bit_idx >= 0; bit_idx--) begin
         cand = root | (64'd1 << bit_idx);
         if (128'(cand) * 128'(cand) <= d) root = cand;
      end
      return root;
   endfunction

   // Time for disk A to reach the wall it moves toward; returns hit.
   function automatic logic wall_contact(input logic [POS_W-1:0] p,
                                         input logic signed [VEL_W-1:0] v,
                                         input logic [RAD_W-1:0] r,
                                         output logic [63:0] t);
      longint span;
      longint speed;
      t = '0;
      if (v == 0) return 1'b0;
      if (v > 0) begin
         span = (longint'(1) << FRAC_BITS) - longint'(r) - longint'(p);
         speed = longint'(v);
      end else begin
         span = longint'(p) - longint'(r);
         speed = -longint'(v);
      end
      if (span > 0) t = (64'(span) << FRAC_BITS) / 64'(speed);
      return 1'b1;
   endfunction

   // Time until the two disks touch; returns hit.
   function automatic logic pair_contact(input request_type rq, output logic [63:0] t);
      longint dpx, dpy, dvx, dvy, dot, vv, pp, s, e;
      logic [127:0] b2, ve;
      logic [63:0] nb, root;
      t = '0;
      dpx = longint'(rq.bx) - longint'(rq.ax);
      dpy = longint'(rq.by) - longint'(rq.ay);
      dvx = longint'(rq.vbx) - longint'(rq.vax);
      dvy = longint'(rq.vby) - longint'(rq.vay);
      dot = dpx * dvx + dpy * dvy;
      if (dot >= 0) return 1'b0;
      vv = dvx * dvx + dvy * dvy;
      pp = dpx * dpx + dpy * dpy;
      s = longint'(rq.ra) + longint'(rq.rb) + longint'(margin);
      e = pp - s * s;
      if (e < 0) return 1'b1;
      nb = 64'(-dot);
      b2 = 128'(nb) * 128'(nb);
      ve = 128'(64'(vv)) * 128'(64'(e));
      if (ve > b2) return 1'b0;
      root = floor_root(b2 - ve);
      t = ((nb - root) << FRAC_BITS) / 64'(vv);
      return 1'b1;
   endfunction

   // Expected response for one request under the current settings.
   function automatic contact_type predict_contact(input request_type rq);
      contact_type c;
      logic [63:0] t;
      logic [63:0] total;
      logic hit;
      t = '0;
      case (rq.kind)
         REQ_PAIR:   hit = pair_contact(rq, t);
         REQ_WALL_X: hit = wall_contact(rq.ax, rq.vax, rq.ra, t);
         REQ_WALL_Y: hit = wall_contact(rq.ay, rq.vay, rq.ra, t);
         default:    hit = 1'b0;
      endcase
      if (hit && t > 64'(horizon)) hit = 1'b0;
      c.hit = hit;
      c.when = '0;
      if (hit) begin
         total = 64'(rq.now) + t;
         c.when = (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
      end
      return c;
   endfunction

   // Random gap: mostly none or short, sometimes long.
   function automatic int random_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic request_type random_request();
      request_type rq;
      int shape;
      rq.kind = TYPE_W'($urandom_range(0, 99) < 55 ? REQ_PAIR :
                        ($urandom_range(0, 1) ? REQ_WALL_X : REQ_WALL_Y));
      if ($urandom_range(0, 49) == 0) rq.kind = 2'd3;
      rq.now = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 1 << 20)
                                           : $urandom();
      rq.ax = POS_W'($urandom()); rq.ay = POS_W'($urandom());
      rq.bx = POS_W'($urandom()); rq.by = POS_W'($urandom());
      rq.vax = VEL_W'($urandom()); rq.vay = VEL_W'($urandom());
      rq.vbx = VEL_W'($urandom()); rq.vby = VEL_W'($urandom());
      rq.ra = RAD_W'($urandom()); rq.rb = RAD_W'($urandom());
      shape = $urandom_range(0, 3);
      // Most pairs are aimed at each other at close range so that hits are common.
      if (rq.kind == REQ_PAIR && shape != 0) begin
         rq.bx = rq.ax + POS_W'($urandom_range(0, 8000)) - POS_W'(4000);
         rq.by = rq.ay + POS_W'($urandom_range(0, 8000)) - POS_W'(4000);
         rq.ra = RAD_W'($urandom_range(0, 1500));
         rq.rb = RAD_W'($urandom_range(0, 1500));
         rq.vbx = VEL_W'(($signed({1'b0, rq.ax}) - $signed({1'b0, rq.bx})) >>> 1);
         rq.vby = VEL_W'(($signed({1'b0, rq.ay}) - $signed({1'b0, rq.by})) >>> 1);
         rq.vax = VEL_W'($urandom_range(0, 4000)) - VEL_W'(2000);
         rq.vay = VEL_W'($urandom_range(0, 4000)) - VEL_W'(2000);
      end else if (rq.kind != REQ_PAIR && shape == 1) begin
         rq.vax = $signed(VEL_W'($urandom_range(0, 3))) - 18'sd2;
         rq.vay = $signed(VEL_W'($urandom_range(0, 3))) - 18'sd2;
      end
      return rq;
   endfunction

   function automatic request_type make_request(input logic [TYPE_W-1:0] kind,
         input logic [NOW_W-1:0] now, input logic [POS_W-1:0] ax, ay,
         input logic signed [VEL_W-1:0] vax, vay, input logic [RAD_W-1:0] ra,
         input logic [POS_W-1:0] bx, by, input logic signed [VEL_W-1:0] vbx, vby,
         input logic [RAD_W-1:0] rb);
      request_type rq;
      rq.kind = kind; rq.now = now; rq.ax = ax; rq.ay = ay; rq.vax = vax; rq.vay = vay;
      rq.ra = ra; rq.bx = bx; rq.by = by; rq.vbx = vbx; rq.vby = vby; rq.rb = rb;
      return rq;
   endfunction

   task automatic add_row(input request_type rq, input logic fixed,
                          input logic hit, input logic [NOW_W-1:0] when);
      directed_row_type row;
      row.rq = rq;
      row.check_fixed = fixed;
      row.answer.hit = hit;
      row.answer.when = when;
      directed.push_back(row);
   endtask

   // Offer one transaction and wait until it is taken.
   task automatic send_request(input request_type rq, input logic fixed,
                               input contact_type answer);
      req_type <= rq.kind; req_now_time <= rq.now;
      req_pos_ax <= rq.ax; req_pos_ay <= rq.ay; req_vel_ax <= rq.vax;
      req_vel_ay <= rq.vay; req_radius_a <= rq.ra; req_pos_bx <= rq.bx;
      req_pos_by <= rq.by; req_vel_bx <= rq.vbx; req_vel_by <= rq.vby;
      req_radius_b <= rq.rb;
      req_valid <= 1'b1;
      pending_contacts.push_back(fixed ? answer : predict_contact(rq));
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic idle_sender(input int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(negedge clock);
      end
   endtask

   task automatic write_register(input ctp_csr_type index, input logic [CSR_W-1:0] value);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      if (index == CSR_HORIZON) horizon = value[HOR_W-1:0];
      else margin = value[MAR_W-1:0];
   endtask

   // Let the pipeline drain before touching the registers.
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (pending_contacts.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   // Receiver: random stalls, and one long hold-off while the sender keeps going.
   initial begin
      rsp_stall = 1'b1;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_long) begin
            rsp_stall <= 1'b1;
            repeat (200) @(negedge clock);
            hold_long = 1'b0;
         end
         if ($urandom_range(0, 30) == 0 && !stimulus_done) begin
            rsp_stall <= 1'b1;
            repeat (random_gap()) @(negedge clock);
         end else begin
            rsp_stall <= ($urandom_range(0, 3) == 0 && !stimulus_done);
         end
         @(negedge clock);
      end
   end

   // Response checker.
   always @(posedge clock) begin
      contact_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_contacts.size() == 0) begin
            report_mismatch("unexpected transaction", {63'd0, rsp_hit}, 64'd0);
         end else begin
            want = pending_contacts.pop_front();
            if (rsp_hit !== want.hit) report_mismatch("hit", rsp_hit, want.hit);
            if (rsp_event_time !== want.when)
               report_mismatch("event_time", rsp_event_time, want.when);
         end
      end
   end

   // Stimulus.
   initial begin
      int waited;
      error_count = 0;
      hold_long = 1'b0;
      stimulus_done = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_type = '0; req_now_time = '0;
      req_pos_ax = '0; req_pos_ay = '0; req_vel_ax = '0; req_vel_ay = '0;
      req_radius_a = '0; req_pos_bx = '0; req_pos_by = '0; req_vel_bx = '0;
      req_vel_by = '0; req_radius_b = '0;
      csr_write = 1'b0; csr_index = CSR_HORIZON; csr_wdata = '0;
      horizon = HORIZON_RESET;
      margin = MARGIN_RESET;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed rows under reset settings.
      // Wall at rest never hits.
      add_row(make_request(REQ_WALL_X, 32'd100, 16'd1000, 16'd0, 18'sd0, 18'sd0, 13'd0,
              0, 0, 0, 0, 0), 1'b1, 1'b0, 32'd0);
      // Moving right from x=0 at speed 2^16: one second to the wall.
      add_row(make_request(REQ_WALL_X, 32'd5, 16'd0, 16'd0, 18'sd65536, 18'sd0, 13'd0,
              0, 0, 0, 0, 0), 1'b1, 1'b1, 32'd65541);
      // Moving down in y, already past the wall: time clamps to zero.
      add_row(make_request(REQ_WALL_Y, 32'd77, 16'd0, 16'd10, 18'sd0, -18'sd5, 13'd8191,
              0, 0, 0, 0, 0), 1'b1, 1'b1, 32'd77);
      // Near the end of time the sum saturates.
      add_row(make_request(REQ_WALL_Y, 32'hFFFF_FFFF, 16'd0, 16'd0, 18'sd0, 18'sd65536,
              13'd0, 0, 0, 0, 0, 0), 1'b1, 1'b1, 32'hFFFF_FFFF);
      // Slowest leftward wall approach is far beyond the horizon.
      add_row(make_request(REQ_WALL_X, 32'd0, 16'hFFFF, 16'hFFFF, -18'sd1, 18'sd131071,
              13'd0, 0, 0, 0, 0, 0), 1'b1, 1'b0, 32'd0);
      // Unused selector never hits.
      add_row(make_request(2'd3, 32'd9, 16'd1, 16'd1, 18'sd100, 18'sd100, 13'd1,
              16'd2, 16'd2, -18'sd100, -18'sd100, 13'd1), 1'b1, 1'b0, 32'd0);
      // Overlapping disks closing in: time zero.
      add_row(make_request(REQ_PAIR, 32'd1234, 16'd100, 16'd100, 18'sd10, 18'sd0, 13'd50,
              16'd120, 16'd100, -18'sd10, 18'sd0, 13'd50), 1'b1, 1'b1, 32'd1234);
      // Separating disks never hit.
      add_row(make_request(REQ_PAIR, 32'd0, 16'd100, 16'd100, -18'sd10, 18'sd0, 13'd0,
              16'd5000, 16'd100, 18'sd10, 18'sd0, 13'd0), 1'b1, 1'b0, 32'd0);
      // Extremes of velocity and position, and some moderate cases, checked against the predictor.
      add_row(make_request(REQ_PAIR, 32'hFFFF_0000, 16'd0, 16'd0, 18'sd131071, 18'sd131071,
              13'd8191, 16'hFFFF, 16'hFFFF, -18'sd131072, -18'sd131072, 13'd8191),
              1'b0, 1'b0, 32'd0);
      add_row(make_request(REQ_PAIR, 32'd0, 16'd0, 16'd30000, 18'sd5000, 18'sd0, 13'd200,
              16'd40000, 16'd30000, -18'sd5000, 18'sd0, 13'd300), 1'b0, 1'b0, 32'd0);
      add_row(make_request(REQ_PAIR, 32'd7, 16'd0, 16'd0, 18'sd3000, 18'sd0, 13'd100,
              16'd20000, 16'd9000, 18'sd0, 18'sd0, 13'd100), 1'b0, 1'b0, 32'd0);
      add_row(make_request(REQ_WALL_X, 32'd0, 16'hFFFF, 16'd0, -18'sd131072, 18'sd0,
              13'd8191, 0, 0, 0, 0, 0), 1'b0, 1'b0, 32'd0);
      add_row(make_request(REQ_WALL_Y, 32'd3, 16'd0, 16'd0, 18'sd0, 18'sd1, 13'd8191,
              0, 0, 0, 0, 0), 1'b0, 1'b0, 32'd0);
      foreach (directed[i]) begin
         send_request(directed[i].rq, directed[i].check_fixed, directed[i].answer);
         idle_sender(random_gap());
      end
      drain_pipeline();

      // Random phases through several register settings, extremes included.
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin write_register(CSR_HORIZON, 20'hFFFFF); write_register(CSR_MARGIN, 0); end
            1: begin write_register(CSR_HORIZON, 0); write_register(CSR_MARGIN, 10'h3FF); end
            2: begin write_register(CSR_HORIZON, 20'd1000); write_register(CSR_MARGIN, 66); end
            default: begin
               write_register(CSR_HORIZON, CSR_W'($urandom()));
               write_register(CSR_MARGIN, CSR_W'($urandom()));
            end
         endcase
         for (int n = 0; n < 180; n++) begin
            if (phase == 3 && n == 20) hold_long = 1'b1;
            send_request(random_request(), 1'b0, '{1'b0, 32'd0});
            if ($urandom_range(0, 2) == 0 || (phase == 3 && n >= 20 && n < 120))
               continue;
            idle_sender(random_gap());
         end
         drain_pipeline();
      end

      // Final drain with a bounded wait.
      stimulus_done = 1'b1;
      req_valid <= 1'b0;
      waited = 0;
      while (pending_contacts.size() != 0 && waited < 100000) begin
         @(negedge clock);
         waited++;
      end
      repeat (LATENCY + 4) @(negedge clock);
      if (error_count == 0 && pending_contacts.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
